/* design/segment_rms_envelope_defines.svh */
// Assertion macros shared by the RTL files.
`ifndef SEGMENT_RMS_ENVELOPE_DEFINES_SVH
`define SEGMENT_RMS_ENVELOPE_DEFINES_SVH

`ifndef SYNTHESIS

// prop must hold at every clock edge outside reset
`define SRE_ASSERT(label, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("segment_rms_envelope: assertion failed");

// cond must never be true at a clock edge outside reset
`define SRE_NEVER(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("segment_rms_envelope: forbidden condition seen");

`else

`define SRE_ASSERT(label, prop)
`define SRE_NEVER(label, cond)

`endif

`endif

/* design/sre_pkg.sv */
package sre_pkg;

    localparam int SEGMENT_BITS = 16;
    localparam int SUM_BITS     = 15 + SEGMENT_BITS;
    localparam int ROOT_W       = (SUM_BITS + 1) / 2;
    localparam int RAD_W        = 2 * ROOT_W;
    localparam int STEP_W       = $clog2(SUM_BITS);

    localparam int SAMPLE_W     = 32;
    localparam int LEVEL_W      = 8;
    localparam int CFG_W        = 16;
    localparam int IDX_W        = 2;
    localparam int CMP_W        = 32;

    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

    localparam logic [CMP_W-1:0] COUNT_MAX = CMP_W'((64'd1 << SEGMENT_BITS) - 64'd1);
    localparam logic [ROOT_W-1:0] LEVEL_MAX = ROOT_W'(128);

    // register indexes
    localparam logic [IDX_W-1:0] REG_SAMPLE_TYPE    = 2'd0;
    localparam logic [IDX_W-1:0] REG_SEGMENT_LENGTH = 2'd1;

    // sample type codes; the unused code acts as int32
    localparam logic [1:0] TYPE_INT8  = 2'd0;
    localparam logic [1:0] TYPE_INT16 = 2'd1;
    localparam logic [1:0] TYPE_INT32 = 2'd2;

    localparam logic [CFG_W-1:0] SEGMENT_LENGTH_RESET = 16'd256;

    typedef struct packed {
        logic [SUM_BITS-1:0]     sum;
        logic [SEGMENT_BITS-1:0] count;
        logic                    last;
    } job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

/* design/segment_rms_envelope.sv */
// Channel   Ports                                  Handshake
// config    cfg_write cfg_index cfg_data           write when cfg_write high
// input     sample_value end_of_buffer             push & !full
// result    rms_level last_level                   pop & !empty
//
// Samples accumulate at one word per cycle unless full is high; full rises only
// while the four-entry segment queue is full.
// Each closed segment passes through the back end as a load, one quotient bit a
// cycle in the divider, one root bit a cycle in the square root, then write-out.
// A result waits in the output register until popped; meanwhile the back end can
// work on the next segment but holds in its write state.
// Reset clears the sums, counts, queue pointers and result flag at once.
module segment_rms_envelope
    import sre_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    input  logic                push,
    output logic                full,
    input  logic [SAMPLE_W-1:0] sample_value,
    input  logic                end_of_buffer,
    output logic                empty,
    input  logic                pop,
    output logic [LEVEL_W-1:0]  rms_level,
    output logic                last_level
);

    q_status_t q_status;
    job_t      job_in;
    job_t      job_out;
    logic      q_push;
    logic      q_pop;

    sre_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .push          (push),
        .sample_value  (sample_value),
        .end_of_buffer (end_of_buffer),
        .q_status      (q_status),
        .q_push        (q_push),
        .q_job         (job_in)
    );

    sre_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_push    (q_push),
        .q_job_in  (job_in),
        .q_pop     (q_pop),
        .q_job_out (job_out),
        .q_status  (q_status)
    );

    sre_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_status   (q_status),
        .q_job      (job_out),
        .q_pop      (q_pop),
        .pop        (pop),
        .empty      (empty),
        .rms_level  (rms_level),
        .last_level (last_level)
    );

    assign full = q_status.full;

endmodule

/* design/sre_front.sv */
module sre_front
    import sre_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    input  logic                push,
    input  logic [SAMPLE_W-1:0] sample_value,
    input  logic                end_of_buffer,
    input  q_status_t           q_status,
    output logic                q_push,
    output job_t                q_job
);

    logic [1:0]              sample_type_reg;
    logic [CFG_W-1:0]        seg_len_reg;
    logic [SUM_BITS-1:0]     sum_reg;
    logic [SUM_BITS-1:0]     sum_next;
    logic [SEGMENT_BITS-1:0] cnt_reg;
    logic [SEGMENT_BITS-1:0] cnt_next;

    logic [7:0]       top;
    logic [7:0]       mag;
    logic [15:0]      square;
    logic [CMP_W-1:0] len_ext;
    logic [CMP_W-1:0] len_eff;
    logic             accept;
    logic             emit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_type_reg <= TYPE_INT16;
            seg_len_reg     <= SEGMENT_LENGTH_RESET;
        end
        else if (cfg_write)
        begin
            if (cfg_index == REG_SAMPLE_TYPE)
                sample_type_reg <= cfg_data[1:0];
            else if (cfg_index == REG_SEGMENT_LENGTH)
                seg_len_reg <= cfg_data;
        end
    end

    always_comb
    begin
        case (sample_type_reg)
            TYPE_INT8:  top = sample_value[7:0];
            TYPE_INT16: top = sample_value[15:8];
            default:    top = sample_value[31:24];
        endcase
        // -128 maps to 128 as unsigned
        mag    = top[7] ? (~top + 8'd1) : top;
        square = mag * mag;
    end

    always_comb
    begin
        len_ext = CMP_W'(seg_len_reg);
        if (len_ext == '0)
            len_eff = CMP_W'(1);
        else if (len_ext > COUNT_MAX)
            len_eff = COUNT_MAX;
        else
            len_eff = len_ext;
    end

    assign accept   = push && !q_status.full;
    assign sum_next = sum_reg + SUM_BITS'(square);
    assign cnt_next = cnt_reg + SEGMENT_BITS'(1);
    assign emit     = (CMP_W'(cnt_next) >= len_eff) || end_of_buffer;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            cnt_reg <= '0;
        end
        else if (accept)
        begin
            if (emit)
            begin
                sum_reg <= '0;
                cnt_reg <= '0;
            end
            else
            begin
                sum_reg <= sum_next;
                cnt_reg <= cnt_next;
            end
        end
    end

    assign q_push      = accept && emit;
    assign q_job.sum   = sum_next;
    assign q_job.count = cnt_next;
    assign q_job.last  = end_of_buffer;

endmodule

/* design/sre_queue.sv */
module sre_queue
    import sre_pkg::*;
`include "segment_rms_envelope_defines.svh"
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      q_push,
    input  job_t      q_job_in,
    input  logic      q_pop,
    output job_t      q_job_out,
    output q_status_t q_status
);

    job_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   fill_reg;
    logic              do_push;
    logic              do_pop;

    assign q_status.full  = (fill_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign q_status.empty = (fill_reg == '0);

    assign do_push = q_push && !q_status.full;
    assign do_pop  = q_pop && !q_status.empty;

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= q_job_in;
    end

    assign q_job_out = slot_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            if (do_push && !do_pop)
                fill_reg <= fill_reg + (QPTR_W + 1)'(1);
            else if (do_pop && !do_push)
                fill_reg <= fill_reg - (QPTR_W + 1)'(1);
        end
    end

    `SRE_NEVER(a_push_when_full, q_push && q_status.full)
    `SRE_NEVER(a_pop_when_empty, q_pop && q_status.empty)
    `SRE_ASSERT(a_fill_bound, fill_reg <= (QPTR_W + 1)'(QUEUE_DEPTH))

endmodule

/* design/sre_back.sv */
module sre_back
    import sre_pkg::*;
`include "segment_rms_envelope_defines.svh"
(
    input  logic               clk,
    input  logic               rst_n,
    input  q_status_t          q_status,
    input  job_t               q_job,
    output logic               q_pop,
    input  logic               pop,
    output logic               empty,
    output logic [LEVEL_W-1:0] rms_level,
    output logic               last_level
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_DIV   = 4'b0010,
        ST_SQRT  = 4'b0100,
        ST_WRITE = 4'b1000
    } state_t;

    state_t                  state_reg;
    state_t                  state_next;
    logic [STEP_W-1:0]       step_reg;
    logic [SUM_BITS-1:0]     dvd_reg;
    logic [SEGMENT_BITS-1:0] dvs_reg;
    logic [SEGMENT_BITS-1:0] rem_reg;
    logic                    last_reg;
    logic [RAD_W-1:0]        rad_reg;
    logic [ROOT_W-1:0]       root_reg;
    logic [ROOT_W:0]         srem_reg;
    logic [LEVEL_W-1:0]      out_level_reg;
    logic                    out_last_reg;
    logic                    out_valid_reg;

    logic [SEGMENT_BITS:0]   rem_sh;
    logic                    div_ge;
    logic [SEGMENT_BITS-1:0] rem_next;
    logic [SUM_BITS-1:0]     dvd_next;
    logic [ROOT_W+2:0]       srem_sh;
    logic [ROOT_W+2:0]       trial;
    logic                    sqrt_ge;
    logic [ROOT_W:0]         srem_next;
    logic [ROOT_W-1:0]       root_next;
    logic                    out_pop;
    logic                    out_write;

    // restoring divide, one quotient bit per cycle; quotient fills dvd_reg from the bottom
    always_comb
    begin
        rem_sh   = {rem_reg, dvd_reg[SUM_BITS-1]};
        div_ge   = rem_sh >= {1'b0, dvs_reg};
        rem_next = div_ge ? SEGMENT_BITS'(rem_sh - {1'b0, dvs_reg})
                          : rem_sh[SEGMENT_BITS-1:0];
        dvd_next = {dvd_reg[SUM_BITS-2:0], div_ge};
    end

    // digit-by-digit square root, one root bit per cycle
    always_comb
    begin
        srem_sh   = {srem_reg, rad_reg[RAD_W-1 -: 2]};
        trial     = {1'b0, root_reg, 2'b01};
        sqrt_ge   = srem_sh >= trial;
        srem_next = sqrt_ge ? (ROOT_W + 1)'(srem_sh - trial) : srem_sh[ROOT_W:0];
        root_next = {root_reg[ROOT_W-2:0], sqrt_ge};
    end

    assign out_pop   = pop && out_valid_reg;
    assign out_write = (state_reg == ST_WRITE) && (!out_valid_reg || out_pop);
    assign q_pop     = (state_reg == ST_IDLE) && !q_status.empty;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_status.empty)
                    state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (step_reg == '0)
                    state_next = ST_SQRT;
            end
            ST_SQRT:
            begin
                if (step_reg == '0)
                    state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (out_write)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                dvd_reg  <= q_job.sum;
                dvs_reg  <= q_job.count;
                rem_reg  <= '0;
                last_reg <= q_job.last;
                step_reg <= STEP_W'(SUM_BITS - 1);
            end
            ST_DIV:
            begin
                dvd_reg <= dvd_next;
                rem_reg <= rem_next;
                if (step_reg == '0)
                begin
                    rad_reg  <= RAD_W'(dvd_next);
                    root_reg <= '0;
                    srem_reg <= '0;
                    step_reg <= STEP_W'(ROOT_W - 1);
                end
                else
                    step_reg <= step_reg - STEP_W'(1);
            end
            ST_SQRT:
            begin
                rad_reg  <= {rad_reg[RAD_W-3:0], 2'b00};
                root_reg <= root_next;
                srem_reg <= srem_next;
                step_reg <= step_reg - STEP_W'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (out_write)
        begin
            out_level_reg <= root_reg[LEVEL_W-1:0];
            out_last_reg  <= last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_write)
            out_valid_reg <= 1'b1;
        else if (out_pop)
            out_valid_reg <= 1'b0;
    end

    assign empty      = !out_valid_reg;
    assign rms_level  = out_level_reg;
    assign last_level = out_last_reg;

    `SRE_ASSERT(a_div_nonzero, (state_reg == ST_DIV) |-> (dvs_reg != '0))
    `SRE_ASSERT(a_level_range, (state_reg == ST_WRITE) |-> (root_reg <= LEVEL_MAX))
    `SRE_ASSERT(a_div_to_sqrt, (state_reg == ST_DIV && step_reg == '0) |=> (state_reg == ST_SQRT && root_reg == '0))
    `SRE_ASSERT(a_result_kept, (out_valid_reg && !pop) |=> out_valid_reg)

endmodule

/* tb/tb.sv */
module tb;
    import sre_pkg::*;

    localparam logic [1:0] TYPE_SPARE     = 2'd3;
    localparam int         DRAIN_CYCLES   = 300;
    localparam int         LONG_HOLD      = 400;
    localparam int         WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        logic [SAMPLE_W-1:0] value;
        logic                eob;
    } sample_word_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic               last;
    } level_word_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_write = 1'b0;
    logic [IDX_W-1:0]    cfg_index = REG_SAMPLE_TYPE;
    logic [CFG_W-1:0]    cfg_data = '0;
    logic                push = 1'b0;
    logic                full;
    logic [SAMPLE_W-1:0] sample_value = '0;
    logic                end_of_buffer = 1'b0;
    logic                empty;
    logic                pop = 1'b0;
    logic [LEVEL_W-1:0]  rms_level;
    logic                last_level;

    segment_rms_envelope u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_write     (cfg_write),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .push          (push),
        .full          (full),
        .sample_value  (sample_value),
        .end_of_buffer (end_of_buffer),
        .empty         (empty),
        .pop           (pop),
        .rms_level     (rms_level),
        .last_level    (last_level)
    );

    always #5 clk = ~clk;

    sample_word_t sample_q[$];
    level_word_t  level_q[$];

    // predictor state
    logic [1:0]              acc_type   = TYPE_INT16;
    logic [CFG_W-1:0]        acc_length = SEGMENT_LENGTH_RESET;
    logic [SUM_BITS-1:0]     acc_sum    = '0;
    logic [SEGMENT_BITS-1:0] acc_count  = '0;

    bit sample_taken = 1'b0;
    int errors       = 0;
    int samples_in   = 0;
    int levels_out   = 0;
    int settings     = 0;
    int idle_cycles  = 0;
    int hold_kick    = 0;

    // sum of squares of the reduced samples; returns 1 when a segment closes
    function automatic bit accumulate_sample(input logic [SAMPLE_W-1:0] value,
                                             input logic eob,
                                             output level_word_t lvl);
        logic [7:0] top;
        int         mag;
        longint     eff_len;
        longint     mean;
        longint     root;
        longint     cand;
        case (acc_type)
            TYPE_INT8:  top = value[7:0];
            TYPE_INT16: top = value[15:8];
            default:    top = value[31:24];
        endcase
        mag = top[7] ? 256 - int'(top) : int'(top);
        eff_len = (acc_length == 0) ? 1 : longint'(acc_length);
        if (eff_len > (longint'(1) << SEGMENT_BITS) - 1)
            eff_len = (longint'(1) << SEGMENT_BITS) - 1;
        acc_sum   = acc_sum + SUM_BITS'(mag * mag);
        acc_count = acc_count + 1'b1;
        lvl = '0;
        if (longint'(acc_count) < eff_len && !eob)
            return 1'b0;
        mean = (acc_count != 0) ? longint'(acc_sum) / longint'(acc_count) : 0;
        root = 0;
        for (int b = 15; b >= 0; b--)
        begin
            cand = root | (longint'(1) << b);
            if (cand * cand <= mean)
                root = cand;
        end
        lvl.level = LEVEL_W'(root);
        lvl.last  = eob;
        acc_sum   = '0;
        acc_count = '0;
        return 1'b1;
    endfunction

    // monitor, scoreboard and watchdog
    always @(posedge clk)
    begin : watch_ports
        level_word_t want;
        level_word_t got;
        bit          moved;
        sample_taken = 1'b0;
        moved        = 1'b0;
        if (rst_n)
        begin
            if (cfg_write)
            begin
                moved = 1'b1;
                if (cfg_index == REG_SAMPLE_TYPE)
                    acc_type = cfg_data[1:0];
                else if (cfg_index == REG_SEGMENT_LENGTH)
                    acc_length = cfg_data;
            end
            if (pop && !empty)
            begin
                moved = 1'b1;
                levels_out++;
                if (level_q.size() == 0)
                begin
                    $error("unexpected word: rms_level=%0d last_level=%0d",
                           rms_level, last_level);
                    errors++;
                end
                else
                begin
                    want = level_q.pop_front();
                    if (rms_level !== want.level)
                    begin
                        $error("rms_level: expected %0d, got %0d", want.level, rms_level);
                        errors++;
                    end
                    if (last_level !== want.last)
                    begin
                        $error("last_level: expected %0d, got %0d", want.last, last_level);
                        errors++;
                    end
                end
            end
            if (push && !full)
            begin
                moved        = 1'b1;
                sample_taken = 1'b1;
                samples_in++;
                if (accumulate_sample(sample_value, end_of_buffer, got))
                    level_q.push_back(got);
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // sample driver: bursts with random gaps
    int burst_left = 0;
    int gap_left   = 0;

    always @(negedge clk)
    begin : drive_samples
        bit offer;
        if (push && sample_taken)
            void'(sample_q.pop_front());
        offer = 1'b0;
        if (rst_n && sample_q.size() > 0)
        begin
            if (push && !sample_taken)
                offer = 1'b1;
            else if (gap_left > 0)
                gap_left--;
            else
            begin
                offer = 1'b1;
                if (burst_left > 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    burst_left = $urandom_range(1, 60);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
        end
        push <= offer;
        if (offer)
        begin
            sample_value  <= sample_q[0].value;
            end_of_buffer <= sample_q[0].eob;
        end
    end

    // receiver: random stall modes, plus a long hold-off on request
    int hold_seen = 0;
    int hold_left = 0;
    int mode      = 0;
    int mode_left = 0;

    always @(negedge clk)
    begin : drive_pop
        bit take;
        if (hold_kick != hold_seen)
        begin
            hold_seen = hold_kick;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            take = 1'b0;
        end
        else
        begin
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (mode)
                0:       take = 1'b1;
                1:       take = ($urandom_range(0, 1) == 1);
                2:       take = ($urandom_range(0, 9) == 0);
                default: take = ($urandom_range(0, 3) != 0);
            endcase
        end
        pop <= take;
    end

    task automatic add_sample(input logic [SAMPLE_W-1:0] value, input logic eob);
        sample_word_t w;
        w.value = value;
        w.eob   = eob;
        sample_q.push_back(w);
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_sample(input logic [1:0] fmt);
        logic [31:0] r;
        r = $urandom;
        case ($urandom_range(0, 6))
            0: return r;
            1:
                case ($urandom_range(0, 3))
                    0:       return 32'h7FFF_FFFF;
                    1:       return 32'h8000_0000;
                    2:       return 32'h0000_0000;
                    default: return 32'hFFFF_FFFF;
                endcase
            2:
                if (fmt == TYPE_INT8)
                    return r[0] ? 32'h0000_007F : 32'hFFFF_FF80;
                else if (fmt == TYPE_INT16)
                    return r[0] ? 32'h0000_7FFF : 32'hFFFF_8000;
                else
                    return r[0] ? 32'h7FFF_FFFF : 32'h8000_0000;
            3:
                // quiet signal, reduced value stays near zero
                if (fmt == TYPE_INT8)
                    return {{28{r[3]}}, r[3:0]};
                else if (fmt == TYPE_INT16)
                    return {{20{r[11]}}, r[11:0]};
                else
                    return {{4{r[27]}}, r[27:0]};
            default:
                if (fmt == TYPE_INT8)
                    return {{24{r[7]}}, r[7:0]};
                else if (fmt == TYPE_INT16)
                    return {{16{r[15]}}, r[15:0]};
                else
                    return r;
        endcase
    endfunction

    // wait until every word is through, then let the back end run dry
    task automatic settle();
        while (sample_q.size() != 0 || push || level_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic apply_setting(input logic [1:0] fmt, input logic [CFG_W-1:0] len);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= REG_SAMPLE_TYPE;
        cfg_data  <= CFG_W'(fmt);
        @(negedge clk);
        cfg_index <= REG_SEGMENT_LENGTH;
        cfg_data  <= len;
        @(negedge clk);
        cfg_write <= 1'b0;
        settings++;
    endtask

    task automatic run_phase(input logic [1:0] fmt, input logic [CFG_W-1:0] len,
                             input int n, input int max_buf, input bit squeeze);
        int left;
        int blen;
        settle();
        apply_setting(fmt, len);
        if (squeeze)
            hold_kick++;
        left = n;
        while (left > 0)
        begin
            blen = $urandom_range(1, max_buf);
            if ($urandom_range(0, 7) == 0)
                blen = 1;
            if (blen > left)
                blen = left;
            for (int i = 0; i < blen; i++)
                add_sample(pick_sample(fmt), i == blen - 1);
            left -= blen;
        end
    endtask

    initial
    begin : stimulus
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset setting: int16, long segments, so only end marks flush
        add_sample(32'h0000_7F00, 1'b0);
        add_sample(32'h0000_8000, 1'b1);
        add_sample(32'h7FFF_FFFF, 1'b1);
        add_sample(32'h8000_0000, 1'b1);
        add_sample(32'h1234_5678, 1'b0);
        add_sample(32'hFFFF_80FF, 1'b1);

        // int8, one sample per level; upper bits outside the format ignored
        settle();
        apply_setting(TYPE_INT8, 16'd1);
        add_sample(32'h0000_0080, 1'b0);
        add_sample(32'h0000_007F, 1'b0);
        add_sample(32'hFFFF_FF80, 1'b0);
        add_sample(32'h1234_56C3, 1'b1);
        add_sample(32'h0000_0000, 1'b0);
        add_sample(32'h0000_0001, 1'b0);

        // int32 with zero length, which behaves as one
        settle();
        apply_setting(TYPE_INT32, 16'd0);
        add_sample(32'h8000_0000, 1'b0);
        add_sample(32'h7FFF_FFFF, 1'b0);
        add_sample(32'h00FF_FFFF, 1'b1);
        add_sample(32'hC000_0000, 1'b0);

        // spare type code acts as int32; end mark exactly at segment end
        settle();
        apply_setting(TYPE_SPARE, 16'd2);
        add_sample(32'h8000_0000, 1'b0);
        add_sample(32'h7F00_0000, 1'b1);
        add_sample(32'h0100_0000, 1'b0);
        add_sample(32'h0200_0000, 1'b1);

        run_phase(TYPE_INT8,  16'd1,                                 155, 8,   1'b0);
        run_phase(TYPE_INT16, 16'd2,                                 155, 16,  1'b0);
        run_phase(TYPE_INT32, 16'd3,                                 155, 16,  1'b0);
        run_phase(TYPE_SPARE, CFG_W'($urandom_range(4, 16)),         155, 64,  1'b0);
        run_phase(TYPE_INT8,  CFG_W'($urandom_range(1, 64)),         155, 100, 1'b0);
        run_phase(TYPE_INT16, 16'hFFFF,                              155, 40,  1'b0);
        run_phase(TYPE_INT32, 16'd0,                                 155, 10,  1'b0);
        run_phase(TYPE_INT16, CFG_W'($urandom_range(17, 120)),       155, 150, 1'b0);
        run_phase(TYPE_INT8,  16'd1,                                 155, 20,  1'b1);
        run_phase(TYPE_INT32, CFG_W'($urandom_range(1, 8)),          155, 30,  1'b0);
        run_phase(TYPE_INT16, CFG_W'($urandom_range(1, 65535)),      155, 40,  1'b0);
        run_phase(TYPE_SPARE, 16'd5,                                 155, 24,  1'b0);

        settle();
        if (level_q.size() != 0)
        begin
            $error("%0d levels never arrived", level_q.size());
            errors += level_q.size();
        end
        $display("run covered %0d samples and %0d levels over %0d register settings,",
                 samples_in, levels_out, settings);
        $display("all sample types, lengths 0/1/max, end marks and a full-queue stall");
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
